FILE: src/sprite_line_compositor_top_assert.svh
// Assertion macros used by the checker module of the sprite line compositor.
// No dependencies.
`ifndef SPRITE_LINE_COMPOSITOR_TOP_ASSERT_SVH
`define SPRITE_LINE_COMPOSITOR_TOP_ASSERT_SVH

// Property checked at every clock edge, including during reset.
`define SLC_ASSERT(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("sprite compositor check failed");

// Property checked only while the active-low reset is released.
`define SLC_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sprite compositor check failed");

`endif

FILE: src/slc_pkg.sv
// Package of the sprite line compositor: operation codes, register indexes,
// state encoding and control structs. No dependencies.
package slc_pkg;

    localparam int TILE_SLOTS_DEF = 34;
    localparam int SLOT_W = 47;
    localparam int OUT_W = 25;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [1:0] {
        OP_NEW_LINE  = 2'd0,
        OP_LOAD_TILE = 2'd1,
        OP_PIXEL     = 2'd2,
        OP_NEW_FRAME = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ABOVE_EN = 3'd0,
        REG_BELOW_EN = 3'd1,
        REG_PLEVEL_0 = 3'd2,
        REG_PLEVEL_1 = 3'd3,
        REG_PLEVEL_2 = 3'd4,
        REG_PLEVEL_3 = 3'd5
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_WAIT = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic new_line;
        logic load;
        logic new_frame;
        logic start;
        logic rd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic disp_empty;
        logic out_free;
    } t_status;

endpackage

FILE: src/slc_ctrl.sv
// Controller of the sprite line compositor: request decode and slot scan sequencing.
// Depends on slc_pkg.
module slc_ctrl import slc_pkg::*; #(
    parameter int TILE_SLOTS = TILE_SLOTS_DEF,
    localparam int CW = $clog2(TILE_SLOTS + 1),
    localparam int SW = (TILE_SLOTS > 1) ? $clog2(TILE_SLOTS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_op,
    input  t_status       i_status,
    input  logic [CW-1:0] i_disp_cnt,
    output t_cmd          o_cmd,
    output logic [SW-1:0] o_rd_idx
);

    t_state r_state, n_state;
    logic [SW-1:0] r_idx, n_idx;
    logic acc;

    assign o_ready = (r_state == S_IDLE);
    assign acc = i_valid && o_ready;
    assign o_rd_idx = r_idx;

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    unique case (t_op'(i_op))
                        OP_NEW_LINE:  o_cmd.new_line = 1'b1;
                        OP_LOAD_TILE: o_cmd.load = 1'b1;
                        OP_NEW_FRAME: o_cmd.new_frame = 1'b1;
                        OP_PIXEL: begin
                            o_cmd.start = 1'b1;
                            n_idx = '0;
                            n_state = i_status.disp_empty ? S_OUT : S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.rd = 1'b1;
                if (CW'(r_idx) == i_disp_cnt - CW'(1)) begin
                    n_state = S_WAIT;
                end else begin
                    n_idx = r_idx + SW'(1);
                end
            end
            S_WAIT: n_state = S_OUT;
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
        end
    end

endmodule

FILE: src/slc_datapath.sv
// Datapath of the sprite line compositor: slot memory, bank counts, pixel
// evaluation, configuration registers and output register. Depends on slc_pkg.
module slc_datapath import slc_pkg::*; #(
    parameter int TILE_SLOTS = TILE_SLOTS_DEF,
    localparam int CW = $clog2(TILE_SLOTS + 1),
    localparam int SW = (TILE_SLOTS > 1) ? $clog2(TILE_SLOTS) : 1,
    localparam int AW = $clog2(2 * TILE_SLOTS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [SW-1:0]         i_rd_idx,
    input  logic [SLOT_W-1:0]     i_tile,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_m_ready,
    output t_status               o_status,
    output logic [CW-1:0]         o_disp_cnt,
    output logic                  o_m_valid,
    output logic [OUT_W-1:0]      o_m_data
);

    logic [SLOT_W-1:0] mem [2*TILE_SLOTS];
    logic [SLOT_W-1:0] r_rdata;
    logic r_rd_v;
    logic r_above_en, r_below_en;
    logic [3:0] r_plevel [4];
    logic r_sel;
    logic [CW-1:0] r_cnt [2];
    logic [8:0] r_pix, r_x;
    logic [7:0] r_hold_a, r_hold_b;
    logic [3:0] r_pri_a, r_pri_b;
    logic r_tover;
    logic r_m_valid;
    logic [OUT_W-1:0] r_m_data;

    logic [AW-1:0] wr_addr, rd_addr;
    logic [CW-1:0] fill_cnt;
    logic [10:0] px;
    logic [2:0] shift;
    logic [31:0] d;
    logic [3:0] color;
    logic hit;
    logic [7:0] pal_idx;

    assign fill_cnt = r_cnt[r_sel];
    assign o_disp_cnt = r_cnt[~r_sel];
    assign o_status.disp_empty = (o_disp_cnt == '0);
    assign o_status.out_free = !r_m_valid || i_m_ready;
    assign o_m_valid = r_m_valid;
    assign o_m_data = r_m_data;

    assign wr_addr = r_sel ? AW'(TILE_SLOTS) + AW'(fill_cnt[SW-1:0]) : AW'(fill_cnt[SW-1:0]);
    assign rd_addr = (~r_sel) ? AW'(TILE_SLOTS) + AW'(i_rd_idx) : AW'(i_rd_idx);

    always_comb begin
        d = r_rdata[46:15];
        px = {2'b00, r_x} - {{2{r_rdata[8]}}, r_rdata[8:0]};
        hit = (px[10:3] == 8'd0);
        shift = r_rdata[14] ? px[2:0] : 3'd7 - px[2:0];
        color = {d[5'd24 + 5'(shift)], d[5'd16 + 5'(shift)],
                 d[5'd8 + 5'(shift)], d[5'(shift)]};
        pal_idx = {1'b1, r_rdata[13:11], color};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && fill_cnt < CW'(TILE_SLOTS)) begin
            mem[wr_addr] <= i_tile;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[rd_addr];
        end
        if (i_cmd.start) begin
            r_x <= r_pix;
        end
        if (i_cmd.emit) begin
            r_m_data <= {r_tover, r_pri_b, r_hold_b, r_pri_a, r_hold_a};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_above_en <= 1'b0;
            r_below_en <= 1'b0;
            r_plevel <= '{default: 4'd0};
            r_sel <= 1'b0;
            r_cnt <= '{default: '0};
            r_pix <= '0;
            r_hold_a <= '0;
            r_hold_b <= '0;
            r_pri_a <= '0;
            r_pri_b <= '0;
            r_tover <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.rd;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_ABOVE_EN: r_above_en <= i_cfg_data[0];
                    REG_BELOW_EN: r_below_en <= i_cfg_data[0];
                    REG_PLEVEL_0: r_plevel[0] <= i_cfg_data;
                    REG_PLEVEL_1: r_plevel[1] <= i_cfg_data;
                    REG_PLEVEL_2: r_plevel[2] <= i_cfg_data;
                    REG_PLEVEL_3: r_plevel[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.new_line) begin
                r_sel <= ~r_sel;
                r_cnt[~r_sel] <= '0;
                r_pix <= '0;
            end
            if (i_cmd.load) begin
                if (fill_cnt < CW'(TILE_SLOTS)) begin
                    r_cnt[r_sel] <= fill_cnt + CW'(1);
                end else begin
                    r_tover <= 1'b1;
                end
            end
            if (i_cmd.new_frame) begin
                r_tover <= 1'b0;
            end
            if (i_cmd.start) begin
                r_pix <= r_pix + 9'd1;
                r_pri_a <= '0;
                r_pri_b <= '0;
            end
            if (r_rd_v && hit && color != 4'd0) begin
                if (r_above_en) begin
                    r_hold_a <= pal_idx;
                    r_pri_a <= r_plevel[r_rdata[10:9]];
                end
                if (r_below_en) begin
                    r_hold_b <= pal_idx;
                    r_pri_b <= r_plevel[r_rdata[10:9]];
                end
            end
            if (i_cmd.emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: src/sprite_line_compositor_top.sv
// A render pixel request scans the display bank's tiles (S_SCAN, then S_WAIT) and waits
// in S_OUT until the output register is free; with an empty display bank it goes straight
// to S_OUT. No further request is taken until its result is registered; other requests
// leave ready high. The slot scan reads one slot memory entry a cycle.
// Reset (synchronous, active low) empties both banks, clears counters, flags,
// held palettes, registers and the output stage; the slot memory needs no clearing.
module sprite_line_compositor_top import slc_pkg::*; #(
    parameter int TILE_SLOTS = TILE_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // tile_x[8:0], tile_priority[10:9], tile_palette[13:11], tile_hflip[14],
    // tile_data[46:15], zero fill
    input  logic [47:0]           i_s_tdata,
    // operation[1:0]
    input  logic [1:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // above_palette[7:0], above_priority[11:8], below_palette[19:12],
    // below_priority[23:20], time_over[24], zero fill
    output logic [31:0]           o_m_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(TILE_SLOTS + 1);
    localparam int SW = (TILE_SLOTS > 1) ? $clog2(TILE_SLOTS) : 1;

    t_cmd cmd;
    t_status status;
    logic [CW-1:0] disp_cnt;
    logic [SW-1:0] rd_idx;
    logic [OUT_W-1:0] m_data;

    assign o_m_tdata = {7'd0, m_data};

    slc_ctrl #(.TILE_SLOTS(TILE_SLOTS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_s_tvalid), .o_ready(o_s_tready), .i_op(i_s_tuser),
        .i_status(status), .i_disp_cnt(disp_cnt),
        .o_cmd(cmd), .o_rd_idx(rd_idx)
    );

    slc_datapath #(.TILE_SLOTS(TILE_SLOTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .i_rd_idx(rd_idx), .i_tile(i_s_tdata[SLOT_W-1:0]),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_m_ready(i_m_tready),
        .o_status(status), .o_disp_cnt(disp_cnt),
        .o_m_valid(o_m_tvalid), .o_m_data(m_data)
    );

endmodule

FILE: src/slc_checker.sv
// Port-level checks of the sprite line compositor, bound to the top level.
// Depends on slc_pkg and sprite_line_compositor_top_assert.svh.
`include "sprite_line_compositor_top_assert.svh"

module slc_checker import slc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    `SLC_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid)
    `SLC_ASSERT_RST(a_out_stable, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
    `SLC_ASSERT(a_reset_empty, i_clk, !i_rst_n |=> !o_m_tvalid)
    `SLC_ASSERT_RST(a_pixel_busy, i_clk, i_rst_n, i_s_tvalid && o_s_tready && i_s_tuser == OP_PIXEL |=> !o_s_tready)

endmodule

bind sprite_line_compositor_top slc_checker u_slc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tuser(i_s_tuser),
    .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
);

FILE: sim/testbench.sv
// Self-checking testbench for sprite_line_compositor_top: line, tile, pixel and frame
// requests are driven on the input stream, pixels are predicted and compared.
// Depends on slc_pkg and the compositor RTL.
module testbench;
    import slc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = TILE_SLOTS_DEF;

    typedef struct packed {
        logic [31:0] data;
        logic        hflip;
        logic [2:0]  pal;
        logic [1:0]  pri;
        logic [8:0]  x;
    } t_tile;

    typedef struct packed {
        t_op   op;
        t_tile tile;
    } t_request;

    typedef struct packed {
        logic       time_over;
        logic [3:0] below_pri;
        logic [7:0] below_pal;
        logic [3:0] above_pri;
        logic [7:0] above_pal;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [47:0] i_s_tdata = '0;
    logic [1:0] i_s_tuser = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    sprite_line_compositor_top u_dut (.*);

    always #4 i_clk = ~i_clk;

    // Predictor state
    logic        en_above, en_below;
    logic [3:0]  plevel[4];
    t_tile       bank[2][NSLOT];
    int          bank_cnt[2];
    int          fill_cnt;
    logic        fill_sel;
    logic [8:0]  pix_cnt;
    logic [7:0]  hold_above, hold_below;
    logic        over_flag;

    t_request pending_q[$];
    t_pixel   pixel_q[$];
    int  errors = 0;
    int  mismatches = 0;
    bit  quiet = 0;
    bit  hold_off = 0;
    bit  feeding = 0;
    bit  s_acc = 0;

    function automatic void predict(t_request r);
        t_pixel p;
        int sx, px, sh;
        logic [3:0] color;
        t_tile t;
        case (r.op)
            OP_NEW_LINE: begin
                fill_sel = ~fill_sel;
                bank_cnt[fill_sel] = 0;
                fill_cnt = 0;
                pix_cnt = '0;
            end
            OP_LOAD_TILE: begin
                if (fill_cnt >= NSLOT) begin
                    over_flag = 1'b1;
                end else begin
                    bank[fill_sel][fill_cnt] = r.tile;
                    fill_cnt++;
                    bank_cnt[fill_sel] = fill_cnt;
                end
            end
            OP_NEW_FRAME: over_flag = 1'b0;
            default: begin
                p = '0;
                for (int n = 0; n < bank_cnt[~fill_sel]; n++) begin
                    t = bank[~fill_sel][n];
                    sx = t.x[8] ? int'(t.x) - 512 : int'(t.x);
                    px = int'(pix_cnt) - sx;
                    if (px < 0 || px > 7) continue;
                    sh = t.hflip ? px : 7 - px;
                    color = {t.data[sh+24], t.data[sh+16], t.data[sh+8], t.data[sh]};
                    if (color == 0) continue;
                    if (en_above) begin
                        hold_above = 8'd128 + {t.pal, 4'd0} + color;
                        p.above_pri = plevel[t.pri];
                    end
                    if (en_below) begin
                        hold_below = 8'd128 + {t.pal, 4'd0} + color;
                        p.below_pri = plevel[t.pri];
                    end
                end
                pix_cnt = pix_cnt + 1'b1;
                p.above_pal = hold_above;
                p.below_pal = hold_below;
                p.time_over = over_flag;
                pixel_q.push_back(p);
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        s_acc <= i_s_tvalid && o_s_tready;
    end

    // Driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && !s_acc) begin
            end else if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= 12)) begin
                i_s_tvalid <= 1'b1;
                {i_s_tuser, i_s_tdata[46:0]} <= pending_q[0];
                predict(pending_q.pop_front());
            end else begin
                i_s_tvalid <= 1'b0;
            end
            i_m_tready <= !hold_off && (quiet || $urandom_range(99) >= 12);
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        t_pixel got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[24:0];
            if (pixel_q.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected pixel %h", got);
            end else if (got !== pixel_q[0]) begin
                errors++;
                if (mismatches++ < 10)
                    $display("pixel mismatch: expected %h got %h", pixel_q[0], got);
                void'(pixel_q.pop_front());
            end else begin
                void'(pixel_q.pop_front());
            end
        end
    end

    function automatic t_request rand_tile(int x);
        t_request r;
        r.op = OP_LOAD_TILE;
        r.tile.x = 9'(x);
        r.tile.pri = 2'($urandom_range(3));
        r.tile.pal = 3'($urandom_range(7));
        r.tile.hflip = 1'($urandom_range(1));
        r.tile.data = $urandom;
        return r;
    endfunction

    function automatic t_request simple(t_op op);
        t_request r;
        r.op = op;
        r.tile = 47'({$urandom, $urandom});
        return r;
    endfunction

    task automatic write_reg(t_reg idx, logic [3:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ABOVE_EN: en_above = val[0];
            REG_BELOW_EN: en_below = val[0];
            default: plevel[2'(idx - REG_PLEVEL_0)] = val;
        endcase
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || pixel_q.size() > 0) @(posedge i_clk);
        repeat (NSLOT + 10) @(posedge i_clk);
    endtask

    task automatic program_all(logic a, logic b, logic [3:0] p0, logic [3:0] p1,
                               logic [3:0] p2, logic [3:0] p3);
        write_reg(REG_ABOVE_EN, {3'd0, a});
        write_reg(REG_BELOW_EN, {3'd0, b});
        write_reg(REG_PLEVEL_0, p0);
        write_reg(REG_PLEVEL_1, p1);
        write_reg(REG_PLEVEL_2, p2);
        write_reg(REG_PLEVEL_3, p3);
    endtask

    task automatic random_line();
        int ntiles, npix, base;
        t_request r;
        ntiles = ($urandom_range(9) == 0) ? $urandom_range(NSLOT + 3) : $urandom_range(6);
        base = $urandom_range(511);
        for (int i = 0; i < ntiles; i++) begin
            r = rand_tile(($urandom_range(3) == 0) ? $urandom_range(511)
                                                   : (base + $urandom_range(15)) % 512);
            if ($urandom_range(3) == 0) r.tile.data = 32'hffffffff;
            pending_q.push_back(r);
        end
        if ($urandom_range(19) == 0) pending_q.push_back(simple(OP_NEW_FRAME));
        pending_q.push_back(simple(OP_NEW_LINE));
        npix = $urandom_range(12);
        for (int i = 0; i < npix; i++) pending_q.push_back(simple(OP_PIXEL));
    endtask

    initial begin
        t_request r;
        int sent;
        en_above = 1'b0; en_below = 1'b0;
        plevel = '{default: '0};
        bank_cnt = '{0, 0};
        fill_cnt = 0; fill_sel = 1'b0; pix_cnt = '0;
        hold_above = '0; hold_below = '0; over_flag = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: disabled screens, extreme positions, flip, overflow, frame clear.
        pending_q.push_back(simple(OP_PIXEL));
        drain();
        program_all(1'b1, 1'b1, 4'd15, 4'd0, 4'd7, 4'd15);
        r = rand_tile(0); r.tile.data = 32'hffffffff; r.tile.pri = 2'd0; r.tile.pal = 3'd7;
        pending_q.push_back(r);
        r = rand_tile(9'h1fd); r.tile.data = 32'h0f0f0f0f; r.tile.hflip = 1'b1;
        pending_q.push_back(r);
        r = rand_tile(511); r.tile.data = 32'h80000001;
        pending_q.push_back(r);
        pending_q.push_back(simple(OP_NEW_LINE));
        for (int i = 0; i < 10; i++) pending_q.push_back(simple(OP_PIXEL));
        for (int i = 0; i < NSLOT + 2; i++) pending_q.push_back(rand_tile(i % 2));
        pending_q.push_back(simple(OP_NEW_LINE));
        for (int i = 0; i < 3; i++) pending_q.push_back(simple(OP_PIXEL));
        pending_q.push_back(simple(OP_NEW_FRAME));
        pending_q.push_back(simple(OP_PIXEL));
        drain();
        program_all(1'b0, 1'b1, 4'd0, 4'd15, 4'd3, 4'd9);

        // Receiver holds off while the sender keeps offering pixels.
        pending_q.push_back(simple(OP_NEW_LINE));
        for (int i = 0; i < 20; i++) pending_q.push_back(simple(OP_PIXEL));
        hold_off = 1;
        repeat (300) @(posedge i_clk);
        hold_off = 0;
        drain();

        sent = 0;
        for (int phase = 0; phase < 4; phase++) begin
            quiet = (phase == 2);
            while (sent < 125 * (phase + 1)) begin
                random_line();
                sent = 500 - pending_q.size() > sent ? sent : sent;
                sent += 14;
            end
            drain();
            program_all(1'($urandom_range(1)), 1'($urandom_range(1)),
                        4'($urandom_range(15)), 4'($urandom_range(15)),
                        4'($urandom_range(15)), 4'($urandom_range(15)));
        end
        drain();
        if (errors == 0) begin
            $display("sprite_line_compositor_top: match");
        end else begin
            $display("sprite_line_compositor_top: mismatch");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("sprite_line_compositor_top: mismatch");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+src
src/slc_pkg.sv
src/slc_ctrl.sv
src/slc_datapath.sv
src/sprite_line_compositor_top.sv
src/slc_checker.sv
sim/testbench.sv
